### src/hrp_pkg.sv
// Package for the hex record parser: phase codes, kinds, error codes, commands.
// No dependencies.
package hrp_pkg;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_HEX  = 3'd1,
		PH_TAIL = 3'd2,
		PH_SKIP = 3'd3,
		PH_ERR  = 3'd4,
		PH_DONE = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ACT_CHAR    = 2'd0,
		ACT_END     = 2'd1,
		ACT_RESTART = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [3:0] E_NONE    = 4'd0;
	localparam logic [3:0] E_EMPTY   = 4'd1;
	localparam logic [3:0] E_COLON   = 4'd2;
	localparam logic [3:0] E_HEX     = 4'd3;
	localparam logic [3:0] E_SUM     = 4'd4;
	localparam logic [3:0] E_SHORT   = 4'd5;
	localparam logic [3:0] E_COUNT   = 4'd6;
	localparam logic [3:0] E_DLONG   = 4'd7;
	localparam logic [3:0] E_ENDCNT  = 4'd8;
	localparam logic [3:0] E_EXTCNT  = 4'd9;
	localparam logic [3:0] E_TYPE    = 4'd10;
	localparam logic [3:0] E_JUMP    = 4'd11;
	localparam logic [3:0] E_TOOLONG = 4'd12;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;
	localparam logic [7:0] REC_SEG  = 8'h02;
	localparam logic [7:0] REC_LIN  = 8'h04;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IN,     // waiting for an item
		ST_CLOSE,  // line checks decided, apply result
		ST_EMIT,   // send data bytes one per cycle while out_ready
		ST_PAD,    // compute pad count
		ST_FIN,    // send finished item
		ST_ERROUT  // send error item
	} ctl_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic take_char;    // process the held character
		logic restart;      // clear all parse state
		logic clear_line;   // clear line state after a close
		logic set_idle;     // phase back to idle
		logic set_err;      // phase to error stop
		logic set_done;     // phase to finished
		logic load_upper;   // extended address record accepted
		logic emit_load;    // start data byte emission
		logic emit_step;    // current data byte taken
		logic pad_start;    // start pad computation
	} hrp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic       stopped;
		logic       has_text;
		logic [3:0] close_err;
		logic       close_eof;
		logic       close_ext;
		logic       close_data;
		logic       emit_last;
		logic       pad_busy;
		logic       is_newline; // held character ends the line
		logic       emit_zero;  // data record carries no bytes
	} hrp_stat_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0b || c == 8'h0c;
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
		if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'd0;
	endfunction

endpackage

### src/hrp_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type given as a parameter.
interface hrp_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### src/hrp_dp.sv
// Datapath of the hex record parser: line buffer, sums, addresses, pad unit.
// Depends on hrp_pkg.
module hrp_dp #(
	parameter int MAX_DATA_BYTES = 16,
	parameter int LINE_BYTES     = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        chr,
	input  hrp_pkg::hrp_cmd_t cmd,
	output hrp_pkg::hrp_stat_t stat,
	output logic [7:0]        emit_byte,
	output logic [31:0]       emit_addr,
	output logic [31:0]       next_addr,
	output logic [31:0]       pad
);
	localparam int IW = $clog2(LINE_BYTES + 1);

	hrp_pkg::phase_t phase_q;
	logic            text_q, pend_q;
	logic [3:0]      hnib_q, ferr_q;
	logic [IW-1:0]   cnt_q;
	logic [7:0]      sum_q;
	logic [7:0]      buf_q [LINE_BYTES];
	logic [15:0]     upper_q;
	logic [31:0]     next_q;
	logic [IW-1:0]   eidx_q, erem_q;
	logic [31:0]     eaddr_q;
	logic [31:0]     pv_q, pad_q;
	logic [5:0]      plen_q, pones_q;
	logic            pbusy_q;

	logic [4:0]  hv;
	logic [7:0]  nb;
	logic [7:0]  f0, f1, f2, f3, f4, f5;
	logic [IW-1:0] bc;
	logic [31:0] rec_addr;

	assign hv = hrp_pkg::hex_val(chr);
	assign nb = {hnib_q, hv[3:0]};
	assign f0 = buf_q[0];
	assign f1 = buf_q[1];
	assign f2 = buf_q[2];
	assign f3 = buf_q[3];
	assign f4 = buf_q[4];
	assign f5 = buf_q[5];
	assign bc = cnt_q - IW'(5);
	assign rec_addr = {upper_q, f1, f2};

	// Line close decision and the remaining status flags.
	always_comb begin
		stat.stopped    = phase_q == hrp_pkg::PH_ERR || phase_q == hrp_pkg::PH_DONE;
		stat.has_text   = text_q;
		stat.emit_last  = erem_q <= IW'(1);
		stat.pad_busy   = pbusy_q;
		stat.is_newline = chr == 8'h0a;
		stat.emit_zero  = bc == '0;
		stat.close_err  = hrp_pkg::E_NONE;
		stat.close_eof  = 1'b0;
		stat.close_ext  = 1'b0;
		stat.close_data = 1'b0;
		if (ferr_q != hrp_pkg::E_NONE) stat.close_err = ferr_q;
		else if (phase_q == hrp_pkg::PH_IDLE) stat.close_err = hrp_pkg::E_EMPTY;
		else if (pend_q) stat.close_err = hrp_pkg::E_HEX;
		else if (sum_q != 8'd0) stat.close_err = hrp_pkg::E_SUM;
		else if (cnt_q < IW'(5)) stat.close_err = hrp_pkg::E_SHORT;
		else if (9'(bc) != {1'b0, f0}) stat.close_err = hrp_pkg::E_COUNT;
		else if (f3 == hrp_pkg::REC_DATA) begin
			if (9'(bc) > 9'(MAX_DATA_BYTES)) stat.close_err = hrp_pkg::E_DLONG;
			else if (rec_addr != next_q) stat.close_err = hrp_pkg::E_JUMP;
			else stat.close_data = 1'b1;
		end else if (f3 == hrp_pkg::REC_EOF) begin
			if (bc != '0) stat.close_err = hrp_pkg::E_ENDCNT;
			else stat.close_eof = 1'b1;
		end else if (f3 == hrp_pkg::REC_SEG || f3 == hrp_pkg::REC_LIN) begin
			if (bc != IW'(2)) stat.close_err = hrp_pkg::E_EXTCNT;
			else stat.close_ext = 1'b1;
		end else stat.close_err = hrp_pkg::E_TYPE;
	end

	assign emit_byte = buf_q[eidx_q];
	assign emit_addr = eaddr_q;
	assign next_addr = next_q;
	assign pad       = pad_q;

	// Line buffer; only entries written in the current line are read.
	always_ff @(posedge clk) begin
		if (cmd.take_char && phase_q == hrp_pkg::PH_HEX && hv[4] && pend_q &&
		    cnt_q < IW'(LINE_BYTES))
			buf_q[cnt_q] <= nb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrp_pkg::PH_IDLE;
			text_q  <= 1'b0;
			pend_q  <= 1'b0;
			hnib_q  <= '0;
			ferr_q  <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			upper_q <= '0;
			next_q  <= '0;
			eidx_q  <= '0;
			erem_q  <= '0;
			eaddr_q <= '0;
			pv_q    <= '0;
			pad_q   <= '0;
			plen_q  <= '0;
			pones_q <= '0;
			pbusy_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				phase_q <= hrp_pkg::PH_IDLE;
				upper_q <= '0;
				next_q  <= '0;
			end
			if (cmd.restart || cmd.clear_line) begin
				text_q <= 1'b0;
				pend_q <= 1'b0;
				hnib_q <= '0;
				ferr_q <= '0;
				cnt_q  <= '0;
				sum_q  <= '0;
			end
			if (cmd.set_idle) phase_q <= hrp_pkg::PH_IDLE;
			if (cmd.set_err)  phase_q <= hrp_pkg::PH_ERR;
			if (cmd.set_done) phase_q <= hrp_pkg::PH_DONE;
			if (cmd.load_upper) upper_q <= {f4, f5};
			if (cmd.emit_load) begin
				eidx_q  <= IW'(4);
				erem_q  <= bc;
				eaddr_q <= rec_addr;
			end
			if (cmd.emit_step) begin
				eidx_q  <= eidx_q + IW'(1);
				erem_q  <= erem_q - IW'(1);
				eaddr_q <= eaddr_q + 32'd1;
				next_q  <= next_q + 32'd1;
			end
			// Pad unit: scans the size one bit a cycle for length and ones.
			// A start on the last data byte counts that byte as well.
			if (cmd.pad_start) begin
				pv_q    <= cmd.emit_step ? next_q + 32'd1 : next_q;
				plen_q  <= '0;
				pones_q <= '0;
				pbusy_q <= 1'b1;
			end else if (pbusy_q) begin
				if (pv_q != '0) begin
					plen_q  <= plen_q + 6'd1;
					pones_q <= pones_q + 6'(pv_q[0]);
					pv_q    <= pv_q >> 1;
				end else begin
					pbusy_q <= 1'b0;
					if (next_q == '0 || pones_q == 6'd1) pad_q <= '0;
					else pad_q <= 32'((33'd1 << plen_q) - {1'b0, next_q});
				end
			end
			if (cmd.take_char) begin
				text_q <= 1'b1;
				case (phase_q)
					hrp_pkg::PH_IDLE: begin
						if (!hrp_pkg::is_space(chr)) begin
							if (chr == ":") phase_q <= hrp_pkg::PH_HEX;
							else begin
								phase_q <= hrp_pkg::PH_SKIP;
								if (ferr_q == '0)
									ferr_q <= (chr == 8'd0) ? hrp_pkg::E_EMPTY
									                        : hrp_pkg::E_COLON;
							end
						end
					end
					hrp_pkg::PH_HEX: begin
						if (hv[4]) begin
							if (pend_q) begin
								pend_q <= 1'b0;
								if (cnt_q >= IW'(LINE_BYTES)) begin
									phase_q <= hrp_pkg::PH_SKIP;
									if (ferr_q == '0) ferr_q <= hrp_pkg::E_TOOLONG;
								end else begin
									cnt_q <= cnt_q + IW'(1);
									sum_q <= sum_q + nb;
								end
							end else begin
								hnib_q <= hv[3:0];
								pend_q <= 1'b1;
							end
						end else if (hrp_pkg::is_space(chr)) phase_q <= hrp_pkg::PH_TAIL;
						else if (chr == 8'd0) phase_q <= hrp_pkg::PH_SKIP;
						else begin
							phase_q <= hrp_pkg::PH_SKIP;
							if (ferr_q == '0) ferr_q <= hrp_pkg::E_HEX;
						end
					end
					hrp_pkg::PH_TAIL: begin
						if (!hrp_pkg::is_space(chr)) begin
							phase_q <= hrp_pkg::PH_SKIP;
							if (chr != 8'd0 && ferr_q == '0) ferr_q <= hrp_pkg::E_HEX;
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule

### src/hrp_ctl.sv
// Controller of the hex record parser: sequences items, line closes and results.
// Depends on hrp_pkg.
module hrp_ctl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_action,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         out_kind,
	output logic [3:0]         out_err,
	output logic               out_last,
	output logic               out_emit,
	output hrp_pkg::hrp_cmd_t  cmd,
	input  hrp_pkg::hrp_stat_t stat
);
	hrp_pkg::ctl_state_t state_q, state_d;
	logic                eoi_q, eoi_d;
	logic [3:0]          err_q, err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrp_pkg::ST_IN;
			eoi_q   <= 1'b0;
			err_q   <= '0;
		end else begin
			state_q <= state_d;
			eoi_q   <= eoi_d;
			err_q   <= err_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		eoi_d     = eoi_q;
		err_d     = err_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_kind  = hrp_pkg::KIND_DATA;
		out_err   = hrp_pkg::E_NONE;
		out_last  = 1'b0;
		out_emit  = 1'b0;
		case (state_q)
			hrp_pkg::ST_IN: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_action)
						hrp_pkg::ACT_RESTART: cmd.restart = 1'b1;
						hrp_pkg::ACT_CHAR:
							if (!stat.stopped) state_d = hrp_pkg::ST_CLOSE;
						hrp_pkg::ACT_END:
							if (!stat.stopped) state_d = hrp_pkg::ST_CLOSE;
						default: ;
					endcase
					eoi_d = in_action == hrp_pkg::ACT_END;
				end
			end
			hrp_pkg::ST_CLOSE: begin
				// Character held from the accepted item is handled here.
				state_d = hrp_pkg::ST_IN;
				if (eoi_q && !stat.has_text) begin
					cmd.pad_start = 1'b1;
					state_d = hrp_pkg::ST_PAD;
				end else if (eoi_q || stat.is_newline) begin
					cmd.clear_line = 1'b1;
					if (stat.close_err != hrp_pkg::E_NONE) begin
						err_d = stat.close_err;
						cmd.set_err = 1'b1;
						state_d = hrp_pkg::ST_ERROUT;
					end else if (stat.close_eof) begin
						cmd.pad_start = 1'b1;
						state_d = hrp_pkg::ST_PAD;
					end else begin
						cmd.set_idle = 1'b1;
						if (stat.close_ext) cmd.load_upper = 1'b1;
						if (stat.close_data && !stat.emit_zero) begin
							cmd.emit_load = 1'b1;
							state_d = hrp_pkg::ST_EMIT;
						end else if (eoi_q) begin
							cmd.pad_start = 1'b1;
							state_d = hrp_pkg::ST_PAD;
						end
					end
				end else cmd.take_char = 1'b1;
			end
			hrp_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				out_emit  = 1'b1;
				out_last  = stat.emit_last && !eoi_q;
				if (out_ready) begin
					cmd.emit_step = 1'b1;
					if (stat.emit_last) begin
						if (eoi_q) begin
							cmd.pad_start = 1'b1;
							state_d = hrp_pkg::ST_PAD;
						end else state_d = hrp_pkg::ST_IN;
					end
				end
			end
			hrp_pkg::ST_PAD: if (!stat.pad_busy) state_d = hrp_pkg::ST_FIN;
			hrp_pkg::ST_FIN: begin
				out_valid = 1'b1;
				out_kind  = hrp_pkg::KIND_DONE;
				out_last  = 1'b1;
				if (out_ready) begin
					cmd.set_done = 1'b1;
					state_d = hrp_pkg::ST_IN;
				end
			end
			hrp_pkg::ST_ERROUT: begin
				out_valid = 1'b1;
				out_kind  = hrp_pkg::KIND_ERR;
				out_err   = err_q;
				out_last  = 1'b1;
				if (out_ready) state_d = hrp_pkg::ST_IN;
			end
			default: state_d = hrp_pkg::ST_IN;
		endcase
	end
endmodule

### src/hex_record_to_binary_parser_core.sv
// Hex record parser top level. A character item is accepted, then handled
// in a line step in the controller, which takes no new item meanwhile. A
// line end that passes a data record emits one byte item per cycle while
// out_ch is ready; a finish runs a bit-serial pad scan that holds its item
// back. Reset arst_n clears all parse state; the line buffer holds no reset.
module hex_record_to_binary_parser_core #(
	parameter int MAX_DATA_BYTES = 16,
	parameter int LINE_BYTES     = 21
) (
	input logic clk,
	input logic arst_n,
	hrp_if.sink   in_ch,
	hrp_if.source out_ch
);
	hrp_pkg::hrp_cmd_t  cmd;
	hrp_pkg::hrp_stat_t stat;
	logic [7:0]  chr_q;
	logic [7:0]  emit_byte;
	logic [31:0] emit_addr, next_addr, pad;
	logic        c_ready, c_valid, c_last, c_emit;
	logic [1:0]  c_kind;
	logic [3:0]  c_err;

	// The character of the accepted item is held for the line step.
	always_ff @(posedge clk) begin
		if (in_ch.valid && c_ready) chr_q <= in_ch.payload.character;
	end

	assign in_ch.ready = c_ready;

	hrp_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_action (in_ch.payload.action),
		.in_ready  (c_ready),
		.out_ready (out_ch.ready),
		.out_valid (c_valid),
		.out_kind  (c_kind),
		.out_err   (c_err),
		.out_last  (c_last),
		.out_emit  (c_emit),
		.cmd       (cmd),
		.stat      (stat)
	);

	hrp_dp #(.MAX_DATA_BYTES(MAX_DATA_BYTES), .LINE_BYTES(LINE_BYTES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr       (chr_q),
		.cmd       (cmd),
		.stat      (stat),
		.emit_byte (emit_byte),
		.emit_addr (emit_addr),
		.next_addr (next_addr),
		.pad       (pad)
	);

	// Result payload: the total counts the byte being sent for data items.
	assign out_ch.valid              = c_valid;
	assign out_ch.payload.kind       = c_kind;
	assign out_ch.payload.data_byte  = c_emit ? emit_byte : 8'd0;
	assign out_ch.payload.byte_address = c_emit ? emit_addr : 32'd0;
	assign out_ch.payload.total_size = c_emit ? next_addr + 32'd1 : next_addr;
	assign out_ch.payload.pad_count  = (c_kind == hrp_pkg::KIND_DONE) ? pad : 32'd0;
	assign out_ch.payload.error_code = c_err;
	assign out_ch.payload.last       = c_last;
endmodule
